// File: design/eos_pkg.sv
// Package for the elevator order scheduler: widths, codes and shared types.
// Used by eos_ctrl, eos_datapath and elevator_order_scheduler.
package eos_pkg;
    localparam int FLOORS_DEF = 4;
    localparam int FLOOR_W    = 2;

    localparam logic [2:0] FUNC_BUTTON = 3'd0;
    localparam logic [2:0] FUNC_ARRIVE = 3'd1;
    localparam logic [2:0] FUNC_BETWEEN = 3'd2;
    localparam logic [2:0] FUNC_ESTOP  = 3'd3;
    localparam logic [2:0] FUNC_DOOR   = 3'd4;

    localparam logic [1:0] KIND_UP   = 2'd0;
    localparam logic [1:0] KIND_DOWN = 2'd1;
    localparam logic [1:0] KIND_CAB  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // latch the input transaction
        logic eval;     // run the single-step part of the latched transaction
        logic walk;     // evaluate one queue slot of the placement walk
    } eos_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic walk_needed; // a placement walk is in progress
        logic walk_done;   // no slot left to walk
    } eos_sts_t;
endpackage

// File: design/eos_ctrl.sv
// Controller state machine of the elevator order scheduler.
// Depends on eos_pkg; drives eos_datapath through eos_cmd_t / eos_sts_t.
module eos_ctrl
    import eos_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output eos_cmd_t cmd,
    input  eos_sts_t sts
);
    typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_WALK, ST_OUT} state_t;
    state_t state_reg;
    logic   m_valid_reg;

    // Ready when idle and the output register is free or being drained
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd.load = s_tvalid && s_tready;
        cmd.eval = (state_reg == ST_EVAL);
        cmd.walk = (state_reg == ST_WALK) && sts.walk_needed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    state_reg <= ST_WALK;
                end
                ST_WALK: begin
                    if (sts.walk_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: design/eos_datapath.sv
// Datapath of the elevator order scheduler: order bits, destination queue,
// motor and halt state, and the slot-by-slot placement walk. Depends on eos_pkg.
module eos_datapath
    import eos_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  eos_cmd_t           cmd,
    output eos_sts_t           sts,
    input  logic [2:0]         in_func,
    input  logic [1:0]         in_kind,
    input  logic [FLOOR_W-1:0] in_floor,
    output logic signed [1:0]  motor_dir,
    output logic               door_start,
    output logic [3:0]         up_lamps,
    output logic [3:0]         down_lamps,
    output logic [3:0]         cab_lamps,
    output logic [FLOOR_W-1:0] floor_indicator,
    output logic [FLOOR_W-1:0] head_target,
    output logic               queue_empty
);
    localparam int QW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
    localparam int FW = $clog2(FLOORS);      // floor width inside the datapath
    localparam int IW = $clog2(FLOORS + 1);  // slot counter width
    localparam int HW = FW + 2;              // signed half-floor position width
    localparam int SW = FW + 4;              // width of direction differences
    localparam logic [FW-1:0] TOP = FW'(FLOORS - 1);

    logic [FLOORS-1:0] up_reg, dn_reg, cab_reg;
    logic [FW-1:0]     qf_reg [FLOORS];
    logic [FLOORS-1:0] qv_reg;
    logic [FW-1:0]     last_reg;
    logic              at_floor_reg;
    logic signed [1:0] motor_reg, pref_reg, dr_reg;
    logic              halt_reg;
    logic [HW-1:0]     halt_pos_reg;
    logic              door_reg;
    logic [FW-1:0]     f_reg;
    logic [IW-1:0]     idx_reg;
    logic              busy_reg;

    // Latched transaction fields (floor at the package width FLOOR_W)
    logic [2:0]         func_reg;
    logic [1:0]         kind_reg;
    logic [FLOOR_W-1:0] fin_reg;

    function automatic logic signed [1:0] sgn(input logic signed [SW-1:0] d);
        sgn = (d > 0) ? 2'sd1 : ((d < 0) ? -2'sd1 : 2'sd0);
    endfunction

    // Direction from position to head destination
    logic signed [1:0] head_dir;
    always_comb begin
        head_dir = 2'sd0;
        if (qv_reg[0]) begin
            if (halt_reg) begin
                // halt position is signed: a stop below floor 0 reads as -1
                head_dir = sgn($signed({3'b000, qf_reg[0], 1'b0}) -
                               $signed({{2{halt_pos_reg[HW-1]}}, halt_pos_reg}));
            end else begin
                head_dir = sgn($signed({4'b0000, qf_reg[0]}) -
                               $signed({4'b0000, last_reg}));
            end
        end
    end

    logic fin_ok;
    logic [FW-1:0] fin;
    assign fin_ok = ({{(8-FLOOR_W){1'b0}}, fin_reg} < 8'(FLOORS));
    assign fin = FW'(fin_reg);

    // Direction to the head once the car stands at the arrival floor
    logic signed [1:0] arr_dir;
    assign arr_dir = qv_reg[0] ? sgn($signed({4'b0000, qf_reg[0]}) -
                                     $signed({4'b0000, fin})) : 2'sd0;

    // First-step placement decision for a button press
    logic hu, hd, q0hu, q0hd, cs_ok, between0, alongv;
    logic signed [1:0] dr0;
    logic [FW-1:0] q0;
    logic new_up, new_dn, new_cab, press;
    always_comb begin
        new_up  = (kind_reg == KIND_UP) && (fin != TOP) && !up_reg[fin];
        new_dn  = (kind_reg == KIND_DOWN) && (fin != '0) && !dn_reg[fin];
        new_cab = (kind_reg == KIND_CAB) && !cab_reg[fin];
        press   = (func_reg == FUNC_BUTTON) && fin_ok && (new_up || new_dn || new_cab);
        hu = up_reg[fin] || new_up;
        hd = dn_reg[fin] || new_dn;
        q0 = qf_reg[0];
        q0hu = up_reg[q0];
        q0hd = dn_reg[q0];
        if ((cab_reg[fin] || new_cab) || fin == TOP || fin == '0 || (hu && hd)) begin
            dr0 = 2'sd0;
        end else begin
            dr0 = hu ? 2'sd1 : -2'sd1;
        end
        cs_ok = at_floor_reg;
        between0 = ((q0 > last_reg) ? (q0 > fin && last_reg < fin)
                                    : (last_reg > fin && q0 < fin));
        alongv = (head_dir == dr0 || dr0 == 0) &&
                 (between0 || (cs_ok && fin == last_reg));
    end

    // One slot of the placement walk
    logic [QW-1:0] wi;
    logic [FW-1:0] wa, wb;
    logic signed [1:0] wsd;
    logic w_between;
    assign wi = QW'(idx_reg);
    assign wa = qf_reg[wi];
    assign wb = qf_reg[QW'(idx_reg - 1'b1)];
    assign wsd = sgn($signed({4'b0000, wa}) - $signed({4'b0000, wb}));
    assign w_between = ((wa > wb) ? (wa > f_reg && wb < f_reg) : (wb > f_reg && wa < f_reg));

    assign sts.walk_needed = busy_reg;
    assign sts.walk_done = !busy_reg;

    // Clocked update: transaction latch, placement walk and evaluation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg <= '0; dn_reg <= '0; cab_reg <= '0; qv_reg <= '0;
            last_reg <= '0; at_floor_reg <= 1'b0; motor_reg <= 2'sd0;
            pref_reg <= 2'sd0; halt_reg <= 1'b0; halt_pos_reg <= '0;
            door_reg <= 1'b0; busy_reg <= 1'b0;
            idx_reg <= '0; dr_reg <= 2'sd0;
        end else if (cmd.load) begin
            func_reg <= in_func;
            kind_reg <= in_kind;
            fin_reg  <= in_floor;
            door_reg <= 1'b0;
        end else if (cmd.walk) begin
            // Slot walk, one slot per cycle
            if (!qv_reg[wi]) begin
                qf_reg[wi] <= f_reg;
                qv_reg[wi] <= 1'b1;
                busy_reg <= 1'b0;
            end else if (wa == f_reg) begin
                busy_reg <= 1'b0;
            end else if ((wsd == dr_reg || dr_reg == 0) && w_between) begin
                if (dr_reg == 0 && ((wsd > 0 && dn_reg[f_reg]) || (wsd < 0 && up_reg[f_reg]))) begin
                    dr_reg <= -wsd;
                    if (idx_reg == IW'(FLOORS - 1)) busy_reg <= 1'b0;
                    idx_reg <= idx_reg + 1'b1;
                end else begin
                    busy_reg <= 1'b0;
                end
            end else if ((wsd >= 0 && wa <= f_reg) || (wsd <= 0 && wa >= f_reg)) begin
                if ((up_reg[wa] && wsd < 0 && wa < last_reg) ||
                    (dn_reg[wa] && wsd > 0 && wa > last_reg)) begin
                    for (int i = 1; i < FLOORS; i++) begin
                        if (i > int'(idx_reg)) begin
                            qf_reg[i] <= qf_reg[i-1];
                            qv_reg[i] <= qv_reg[i-1];
                        end
                    end
                end
                qf_reg[wi] <= f_reg;
                busy_reg <= 1'b0;
            end else begin
                if (idx_reg == IW'(FLOORS - 1)) busy_reg <= 1'b0;
                idx_reg <= idx_reg + 1'b1;
            end
        end else if (cmd.eval) begin
            // Single-step evaluation of the latched transaction
            case (func_reg)
                FUNC_BUTTON: begin
                    if (press) begin
                        if (new_up) up_reg[fin] <= 1'b1;
                        if (new_dn) dn_reg[fin] <= 1'b1;
                        if (new_cab) cab_reg[fin] <= 1'b1;
                        f_reg <= fin;
                        if (!qv_reg[0]) begin
                            qf_reg[0] <= fin; qv_reg[0] <= 1'b1;
                        end else if (q0 == fin) begin
                        end else if (pref_reg != 0 && cs_ok &&
                                     ((pref_reg > 0 && fin > last_reg) ||
                                      (pref_reg < 0 && fin < last_reg))) begin
                            for (int i = 1; i < FLOORS; i++) begin
                                qf_reg[i] <= qf_reg[i-1]; qv_reg[i] <= qv_reg[i-1];
                            end
                            qf_reg[0] <= fin; qv_reg[0] <= 1'b1;
                            pref_reg <= 2'sd0;
                        end else if (pref_reg != 0 && !cs_ok && pref_reg > 0) begin
                            // sensor reads -1: every floor lies above it
                            for (int i = 1; i < FLOORS; i++) begin
                                qf_reg[i] <= qf_reg[i-1]; qv_reg[i] <= qv_reg[i-1];
                            end
                            qf_reg[0] <= fin; qv_reg[0] <= 1'b1;
                            pref_reg <= 2'sd0;
                        end else if (alongv) begin
                            if ((hu && head_dir < 0) || (hd && head_dir > 0)) begin
                                dr_reg <= -head_dir;
                                busy_reg <= 1'b1;
                                idx_reg <= IW'(1);
                            end
                        end else if ((head_dir > 0 && q0 < fin) || (head_dir < 0 && q0 > fin)) begin
                            if (((q0hu && head_dir < 0) || (q0hd && head_dir > 0)) && !qv_reg[1]) begin
                                for (int i = 1; i < FLOORS; i++) begin
                                    qf_reg[i] <= qf_reg[i-1]; qv_reg[i] <= qv_reg[i-1];
                                end
                                qv_reg[0] <= 1'b1;
                            end
                            qf_reg[0] <= fin;
                        end else begin
                            dr_reg <= dr0;
                            busy_reg <= 1'b1;
                            idx_reg <= IW'(1);
                        end
                    end
                end
                FUNC_ARRIVE: begin
                    if (fin_ok) begin
                        last_reg <= fin; at_floor_reg <= 1'b1;
                        halt_reg <= 1'b0; halt_pos_reg <= '0;
                        if (qv_reg[0] && q0 == fin) begin
                            if (fin != TOP && fin != '0) pref_reg <= motor_reg;
                            for (int i = 0; i < FLOORS - 1; i++) begin
                                qf_reg[i] <= qf_reg[i+1]; qv_reg[i] <= qv_reg[i+1];
                            end
                            qv_reg[FLOORS-1] <= 1'b0;
                            up_reg[fin] <= 1'b0; dn_reg[fin] <= 1'b0; cab_reg[fin] <= 1'b0;
                            motor_reg <= 2'sd0; door_reg <= 1'b1;
                        end else if (cab_reg[fin] || (arr_dir == 1 && up_reg[fin]) ||
                                     (arr_dir == -1 && dn_reg[fin])) begin
                            cab_reg[fin] <= 1'b0;
                            if (up_reg[fin] && arr_dir == 1) up_reg[fin] <= 1'b0;
                            else if (dn_reg[fin] && arr_dir == -1) dn_reg[fin] <= 1'b0;
                            motor_reg <= 2'sd0; door_reg <= 1'b1;
                        end
                    end
                end
                FUNC_BETWEEN: at_floor_reg <= 1'b0;
                FUNC_ESTOP: begin
                    qv_reg <= '0; up_reg <= '0; dn_reg <= '0; cab_reg <= '0;
                    if (at_floor_reg) begin
                        door_reg <= 1'b1;
                    end else begin
                        if (!halt_reg && motor_reg != 0)
                            halt_pos_reg <= HW'({last_reg, 1'b0}) + HW'(motor_reg);
                        halt_reg <= 1'b1;
                    end
                    motor_reg <= 2'sd0;
                end
                FUNC_DOOR: begin
                    if (qv_reg[0]) begin
                        motor_reg <= head_dir;
                        if (head_dir != 0) pref_reg <= 2'sd0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign motor_dir = motor_reg;
    assign door_start = door_reg;
    assign up_lamps = 4'(up_reg);
    assign down_lamps = 4'(dn_reg);
    assign cab_lamps = 4'(cab_reg);
    assign floor_indicator = FLOOR_W'(last_reg);
    assign head_target = qv_reg[0] ? FLOOR_W'(qf_reg[0]) : '0;
    assign queue_empty = !qv_reg[0];
endmodule

// File: design/elevator_order_scheduler.sv
// Elevator order scheduler top level.
// Each transaction runs through the steps accept, evaluate, walk check and
// output, plus a slot-by-slot walk (up to FLOORS-1 slots) when a button order
// is placed further back in the queue. The controller takes one transaction at
// a time; the next input waits until the result is taken.
// Reset: synchronous, active low aresetn; clears orders, queue and motor state.
module elevator_order_scheduler
    import eos_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [2:0] func, [4:3] button_kind, [6:5] floor
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // [1:0] motor_dir, [2] door_start, [6:3] up_lamps,
                                  // [10:7] down_lamps, [14:11] cab_lamps,
                                  // [16:15] floor_indicator, [18:17] head_target,
                                  // [19] queue_empty
);
    eos_cmd_t cmd;
    eos_sts_t sts;
    logic signed [1:0] motor_dir;
    logic door_start, queue_empty;
    logic [3:0] up_lamps, down_lamps, cab_lamps;
    logic [1:0] floor_indicator, head_target;

    eos_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .cmd, .sts
    );

    eos_datapath #(.FLOORS(FLOORS)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .in_func(s_tdata[2:0]), .in_kind(s_tdata[4:3]), .in_floor(s_tdata[6:5]),
        .motor_dir, .door_start, .up_lamps, .down_lamps, .cab_lamps,
        .floor_indicator, .head_target, .queue_empty
    );

    assign m_tdata = {4'b0, queue_empty, head_target, floor_indicator, cab_lamps,
                      down_lamps, up_lamps, door_start, motor_dir};

    // A result never shows an empty queue with a nonzero head
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[19] && m_tdata[18:17] != 2'b00))
        else $error("head_target nonzero with empty queue");
    // Input is never taken while a result waits unconsumed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted over a stalled result");
    // Motor never reported moving together with door start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == 2'b00))
        else $error("door start while motor moving");
endmodule

// File: dv/tb_elevator_order_scheduler.sv
// Self-checking testbench for elevator_order_scheduler: a cycle-free predictor of
// the order bits, destination queue and motor state checks every result transaction.
// Depends on eos_pkg and the elevator_order_scheduler RTL.
module tb_elevator_order_scheduler
    import eos_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FLOORS = FLOORS_DEF;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    elevator_order_scheduler #(.FLOORS(FLOORS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct packed {
        logic [1:0] motor_dir;
        logic       door_start;
        logic [3:0] up_lamps;
        logic [3:0] down_lamps;
        logic [3:0] cab_lamps;
        logic [1:0] floor_ind;
        logic [1:0] head_target;
        logic       queue_empty;
    } car_status_t;

    car_status_t status_fifo[$];
    int  err_count    = 0;
    int  status_count = 0;
    int  order_count  = 0;
    bit  tx_idle_on   = 1;
    bit  rx_idle_on   = 1;
    int  rx_hold      = 0;

    // Predictor state of the car
    int         q_fl[FLOORS];
    bit         q_ok[FLOORS];
    logic [3:0] up_calls, dn_calls, cab_calls;
    int         last_fl;
    bit         on_floor;
    int         motor;
    int         pref_dir;
    bit         halted;
    int         halt_pos;

    // Clock and reset
    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Timeout at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

    function automatic int sgn(int v);
        return v > 0 ? 1 : (v < 0 ? -1 : 0);
    endfunction

    function automatic int head_heading();
        int t;
        if (!q_ok[0]) return 0;
        if (halted) begin
            t = 2 * q_fl[0];
            return sgn(t - halt_pos);
        end
        return sgn(q_fl[0] - last_fl);
    endfunction

    function automatic void set_motor(int d);
        motor = d;
        if (d != 0) pref_dir = 0;
    endfunction

    function automatic void pop_queue();
        for (int i = 0; i < FLOORS - 1; i++) begin
            q_fl[i] = q_fl[i+1];
            q_ok[i] = q_ok[i+1];
        end
        q_fl[FLOORS-1] = 0;
        q_ok[FLOORS-1] = 0;
    endfunction

    function automatic void push_at(int f, int idx);
        for (int i = FLOORS - 1; i > idx; i--) begin
            q_fl[i] = q_fl[i-1];
            q_ok[i] = q_ok[i-1];
        end
        q_fl[idx] = f;
        q_ok[idx] = 1;
    endfunction

    function automatic void clear_queue();
        for (int i = 0; i < FLOORS; i++) begin
            q_fl[i] = 0;
            q_ok[i] = 0;
        end
    endfunction

    // Place a new order into the destination queue by the route rules
    function automatic void route_order(int f);
        int hu, hd, q0, sd, dr, cs, a, b, hi, lo;
        hu = up_calls[f];
        hd = dn_calls[f];
        if (!q_ok[0]) begin
            q_fl[0] = f;
            q_ok[0] = 1;
            return;
        end
        q0 = q_fl[0];
        if (q0 == f) return;
        sd = head_heading();
        if (cab_calls[f] || f == FLOORS - 1 || f == 0 || (hu && hd)) dr = 0;
        else dr = hu - hd;
        cs = on_floor ? last_fl : -1;
        hi = q0 > last_fl ? q0 : last_fl;
        lo = q0 < last_fl ? q0 : last_fl;

        if (pref_dir != 0 && ((pref_dir > 0 && f > cs) || (pref_dir < 0 && f < cs))) begin
            push_at(f, 0);
            pref_dir = 0;
            return;
        end else if ((sd == dr || dr == 0) && ((hi > f && lo < f) || (cs > -1 && f == cs))) begin
            if ((hu && sd < 0) || (hd && sd > 0)) dr = -sd;
            else return;
        end else if ((sd > 0 && q0 < f) || (sd < 0 && q0 > f)) begin
            if (((up_calls[q0] && sd < 0) || (dn_calls[q0] && sd > 0)) && !q_ok[1]) begin
                push_at(f, 0);
                return;
            end
            q_fl[0] = f;
            return;
        end

        // Walk the later slots
        for (int i = 1; i < FLOORS; i++) begin
            if (!q_ok[i]) begin
                q_fl[i] = f;
                q_ok[i] = 1;
                return;
            end
            a = q_fl[i];
            b = q_fl[i-1];
            if (a == f) return;
            sd = sgn(a - b);
            hi = a > b ? a : b;
            lo = a < b ? a : b;
            if ((sd == dr || dr == 0) && hi > f && lo < f) begin
                if (dr == 0 && ((sd > 0 && hd) || (sd < 0 && hu))) dr = -sd;
                else return;
            end else if ((sd >= 0 && a <= f) || (sd <= 0 && a >= f)) begin
                if ((up_calls[a] && sd < 0 && a < last_fl) ||
                    (dn_calls[a] && sd > 0 && a > last_fl)) begin
                    push_at(f, i);
                    return;
                end
                q_fl[i] = f;
                return;
            end
        end
    endfunction

    // Floor sensor hit: returns 1 when the car stops to serve the floor
    function automatic bit reach_floor(int f);
        int d;
        last_fl  = f;
        on_floor = 1;
        halted   = 0;
        halt_pos = 0;
        if (q_ok[0] && q_fl[0] == f) begin
            if (f < FLOORS - 1 && f > 0) pref_dir = motor;
            pop_queue();
            up_calls[f]  = 0;
            dn_calls[f]  = 0;
            cab_calls[f] = 0;
            set_motor(0);
            return 1;
        end
        d = head_heading();
        if (cab_calls[f] || (d == 1 && up_calls[f]) || (d == -1 && dn_calls[f])) begin
            cab_calls[f] = 0;
            if (up_calls[f] && d == 1) up_calls[f] = 0;
            else if (dn_calls[f] && d == -1) dn_calls[f] = 0;
            set_motor(0);
            return 1;
        end
        return 0;
    endfunction

    function automatic car_status_t predict_status(logic [2:0] fn, logic [1:0] kd, logic [1:0] fl);
        car_status_t st;
        bit door;
        int f;
        door = 0;
        f = int'(fl);
        case (fn)
            FUNC_BUTTON: begin
                if (kd == KIND_UP && f < FLOORS - 1 && !up_calls[f]) begin
                    up_calls[f] = 1;
                    route_order(f);
                end else if (kd == KIND_DOWN && f > 0 && !dn_calls[f]) begin
                    dn_calls[f] = 1;
                    route_order(f);
                end else if (kd == KIND_CAB && !cab_calls[f]) begin
                    cab_calls[f] = 1;
                    route_order(f);
                end
            end
            FUNC_ARRIVE: door = reach_floor(f);
            FUNC_BETWEEN: on_floor = 0;
            FUNC_ESTOP: begin
                clear_queue();
                up_calls = '0; dn_calls = '0; cab_calls = '0;
                if (on_floor) begin
                    door = 1;
                end else begin
                    if (!halted && motor != 0) halt_pos = 2 * last_fl + motor;
                    halted = 1;
                end
                motor = 0;
            end
            FUNC_DOOR: if (q_ok[0]) set_motor(head_heading());
            default: ;
        endcase
        st.motor_dir   = 2'(motor);
        st.door_start  = door;
        st.up_lamps    = up_calls;
        st.down_lamps  = dn_calls;
        st.cab_lamps   = cab_calls;
        st.floor_ind   = 2'(last_fl);
        st.head_target = q_ok[0] ? 2'(q_fl[0]) : 2'd0;
        st.queue_empty = !q_ok[0];
        return st;
    endfunction

    // Send one transaction; valid stays high across back-to-back items
    task automatic send_item(logic [2:0] fn, logic [1:0] kd, logic [1:0] fl);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {1'b0, fl, kd, fn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        status_fifo.push_back(predict_status(fn, kd, fl));
        order_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        @(posedge aclk);
        while (status_fifo.size() != 0) @(posedge aclk);
    endtask

    // Result side: stall draw per transaction, long holds on request
    initial begin
        int wait_cnt;
        car_status_t got, want;
        wait_cnt = 0;
        m_tready <= 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[1:0], m_tdata[2], m_tdata[6:3], m_tdata[10:7],
                        m_tdata[14:11], m_tdata[16:15], m_tdata[18:17], m_tdata[19]};
                status_count++;
                if (status_fifo.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    err_count++;
                end else begin
                    want = status_fifo.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected dir=%0d door=%0b up=%h dn=%h cab=%h ind=%0d head=%0d empty=%0b",
                                 $time, want.motor_dir, want.door_start, want.up_lamps,
                                 want.down_lamps, want.cab_lamps, want.floor_ind,
                                 want.head_target, want.queue_empty);
                        $display("%0t:          actual   dir=%0d door=%0b up=%h dn=%h cab=%h ind=%0d head=%0d empty=%0b",
                                 $time, got.motor_dir, got.door_start, got.up_lamps,
                                 got.down_lamps, got.cab_lamps, got.floor_ind,
                                 got.head_target, got.queue_empty);
                        err_count++;
                    end
                end
                wait_cnt = rx_idle_on ? $urandom_range(0, 12) : 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 0;
            end else if (wait_cnt > 0) begin
                wait_cnt--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    // Extremes, every function code, unused codes and the named corner cases
    task automatic test_directed();
        send_item(FUNC_DOOR,   KIND_UP,   2'd0);   // door done, empty queue
        send_item(FUNC_BUTTON, KIND_UP,   2'd3);   // up call at top: ignored
        send_item(FUNC_BUTTON, KIND_DOWN, 2'd0);   // down call at bottom: ignored
        send_item(FUNC_BUTTON, 2'd3,      2'd2);   // unused kind
        send_item(FUNC_BUTTON, KIND_CAB,  2'd3);
        send_item(FUNC_BUTTON, KIND_CAB,  2'd3);   // already pending
        send_item(FUNC_BUTTON, KIND_UP,   2'd1);
        send_item(FUNC_BUTTON, KIND_DOWN, 2'd2);
        send_item(FUNC_BUTTON, KIND_CAB,  2'd0);   // same as position
        send_item(FUNC_DOOR,   KIND_UP,   2'd0);
        send_item(FUNC_BETWEEN, KIND_UP,  2'd0);
        send_item(FUNC_ARRIVE, KIND_UP,   2'd1);
        send_item(FUNC_DOOR,   KIND_CAB,  2'd0);
        send_item(FUNC_BETWEEN, KIND_DOWN, 2'd1);
        send_item(FUNC_ESTOP,  KIND_UP,   2'd0);   // stop between floors while moving
        send_item(FUNC_ESTOP,  KIND_UP,   2'd0);   // second stop keeps the halt point
        send_item(FUNC_BUTTON, KIND_CAB,  2'd1);
        send_item(FUNC_DOOR,   KIND_UP,   2'd0);
        send_item(3'd5,        KIND_CAB,  2'd3);
        send_item(3'd6,        KIND_DOWN, 2'd1);
        send_item(3'd7,        2'd3,      2'd3);
        send_item(FUNC_ARRIVE, KIND_UP,   2'd2);
        send_item(FUNC_ESTOP,  KIND_CAB,  2'd2);   // stop at a floor
        wait_drained();
    endtask

    // Traffic that mostly follows the car: sensors track the commanded motion
    task automatic test_random_traffic(int n);
        int pick, nxt;
        logic [2:0] fn;
        logic [1:0] kd, fl;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            kd = 2'($urandom_range(0, 3));
            fl = 2'($urandom_range(0, FLOORS - 1));
            nxt = last_fl + motor;
            if (nxt < 0) nxt = 0;
            if (nxt > FLOORS - 1) nxt = FLOORS - 1;
            if (pick < 40) begin
                fn = FUNC_BUTTON;
                if ($urandom_range(0, 9) != 0 && kd == 2'd3) kd = KIND_CAB;
            end else if (pick < 62) begin
                fn = FUNC_ARRIVE;
                if ($urandom_range(0, 9) < 7) fl = 2'(nxt);
            end else if (pick < 76) begin
                fn = FUNC_BETWEEN;
            end else if (pick < 80) begin
                fn = FUNC_ESTOP;
            end else if (pick < 96) begin
                fn = FUNC_DOOR;
            end else begin
                fn = 3'($urandom_range(5, 7));
            end
            send_item(fn, kd, fl);
        end
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        tx_idle_on = 0;
        rx_hold = 300;
        test_random_traffic(60);
        tx_idle_on = 1;
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_drain_pause();
        test_random_traffic(30);
        test_random_traffic(30);
    endtask

    initial begin
        aresetn  <= 0;
        s_tvalid <= 0;
        s_tdata  <= '0;
        clear_queue();
        up_calls = '0; dn_calls = '0; cab_calls = '0;
        last_fl = 0; on_floor = 0; motor = 0; pref_dir = 0;
        halted = 0; halt_pos = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(700);
        tx_idle_on = 0;
        rx_idle_on = 0;
        test_random_traffic(400);
        tx_idle_on = 1;
        rx_idle_on = 1;
        test_backpressure();
        test_drain_pause();
        test_random_traffic(500);

        repeat (20) @(posedge aclk);
        $display("Covered %0d transactions in, %0d results checked: button routing, sensors,",
                 order_count, status_count);
        $display("emergency stops, door events, unused codes, idle gaps and back-pressure.");
        if (err_count == 0 && status_fifo.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
